>>> hdl/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types, codes and helpers for the event stream deframer.
// ----------------------------------------------------------------------------
package eds_pkg;

  localparam int SIZE_WIDTH = 16;  // stored payload size width, 8..16
  localparam int OFF_W      = 16;  // byte offset field width

  localparam logic [7:0] TABLE_CODE = 8'h35;
  localparam logic [7:0] END_CODE   = 8'h39;

  typedef enum logic [2:0] {
    PH_TABLE_CODE,
    PH_TABLE_LEN,
    PH_TABLE_BODY,
    PH_EVENT_CODE,
    PH_PAYLOAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_TABLE,
    ST_BAD_LEN,
    ST_UNKNOWN,
    ST_TRUNC
  } status_t;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_PAYLOAD,
    KIND_TABLE,
    KIND_IGNORED
  } kind_t;

  typedef enum logic [1:0] {
    ENT_CODE,
    ENT_HIGH,
    ENT_LOW
  } entry_step_t;

  typedef struct packed {
    logic [7:0]       byte_out;
    logic [7:0]       event_code;
    logic [OFF_W-1:0] byte_offset;
    kind_t            byte_kind;
    logic             event_last;
    status_t          status;
  } res_t;

  typedef struct packed {
    logic                  en;
    logic [7:0]            addr;
    logic [SIZE_WIDTH-1:0] data;
  } mem_wr_t;

  // table length is bad when zero or when (len - 1) is not a whole number of entries
  function automatic logic len_bad(input logic [7:0] len);
    logic [7:0] dec;
    logic [3:0] dsum;
    logic       rem;
    dec  = len - 8'd1;
    // base-4 digit sum keeps the value mod 3
    dsum = {2'b00, dec[1:0]} + {2'b00, dec[3:2]} + {2'b00, dec[5:4]} + {2'b00, dec[7:6]};
    case (dsum) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: rem = 1'b0;
      default:                       rem = 1'b1;
    endcase
    return (len == 8'd0) || rem;
  endfunction

endpackage

>>> hdl/event_stream_deframer_core.sv
// ----------------------------------------------------------------------------
// event_stream_deframer_core
// Frames a raw event stream one byte per cycle into tagged bytes, unless stalled.
// ----------------------------------------------------------------------------
//  channel | ports               | payload
//  --------+---------------------+------------------------------------------
//  input   | in_tvalid/in_tready | tdata: data_byte; tlast: stream_end
//  result  | out_tvalid/tready   | tdata: byte_out, event_code, byte_offset,
//          |                     | status; tuser: byte_kind; tlast: event_last
//
//  one byte per cycle unless the result side stalls; input register, then
//  result register; the size store read is issued as a byte is taken.
//  after reset the block accepts at once; the size store needs no clearing
//  pass, its entries count only once learned in the current stream.
//  a stall at the result side holds the input stage and then in_tready.
// ----------------------------------------------------------------------------
module event_stream_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] byte_out, [15:8] event_code,
                                  // [31:16] byte_offset, [34:32] status
  output logic [1:0]  out_tuser,  // [1:0] byte_kind
  output logic        out_tlast   // event_last
);
  import eds_pkg::*;

  logic                  stg_v_r, stg_v_nxt;
  logic [7:0]            stg_byte_r;
  logic                  stg_end_r;
  logic                  out_v_r, out_v_nxt;
  res_t                  out_r;
  res_t                  res;
  mem_wr_t               wr;
  logic [SIZE_WIDTH-1:0] size_rd;
  logic                  adv;
  logic                  in_acc;

  assign adv       = stg_v_r && (!out_v_r || out_tready);
  assign in_tready = !stg_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  eds_size_mem u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_tdata),
    .wr      (wr),
    .rd_data (size_rd)
  );

  eds_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .data_byte  (stg_byte_r),
    .stream_end (stg_end_r),
    .size_rd    (size_rd),
    .wr         (wr),
    .res        (res)
  );

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_acc) begin
      stg_v_nxt = 1'b1;
    end else if (adv) begin
      stg_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_tdata;
      stg_end_r  <= in_tlast;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b00000, out_r.status, out_r.byte_offset, out_r.event_code,
                       out_r.byte_out};
  assign out_tuser  = out_r.byte_kind;
  assign out_tlast  = out_r.event_last;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !adv) |-> out_v_r)
    else $error("input stage stalled with an empty result register");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !adv) |-> !in_tready)
    else $error("input taken while the stage is held");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("processed byte not presented as a result");

endmodule

>>> hdl/eds_size_mem.sv
// ----------------------------------------------------------------------------
// eds_size_mem
// Payload size store, 256 entries, one write and one registered read port.
// ----------------------------------------------------------------------------
module eds_size_mem (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [7:0]                     rd_addr,
  input  eds_pkg::mem_wr_t               wr,
  output logic [eds_pkg::SIZE_WIDTH-1:0] rd_data
);
  import eds_pkg::*;

  logic [SIZE_WIDTH-1:0] mem [256];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // a write landing on the same edge as the read is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> hdl/eds_framer.sv
// ----------------------------------------------------------------------------
// eds_framer
// Framing state machine: tags one byte per advance, learns the size table.
// ----------------------------------------------------------------------------
module eds_framer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [7:0]                     data_byte,
  input  logic                           stream_end,
  input  logic [eds_pkg::SIZE_WIDTH-1:0] size_rd,
  output eds_pkg::mem_wr_t               wr,
  output eds_pkg::res_t                  res
);
  import eds_pkg::*;

  phase_t                phase_r, phase_nxt, phase_step;
  status_t               sticky_r, sticky_nxt;
  logic [SIZE_WIDTH-1:0] left_r, left_nxt;
  logic [OFF_W-1:0]      off_r, off_nxt;
  logic [7:0]            cur_r, cur_nxt;
  entry_step_t           step_r, step_nxt;
  logic [7:0]            ecode_r, ecode_nxt;
  logic [7:0]            ehigh_r, ehigh_nxt;
  logic [255:0]          known_r;

  logic                  bad_len;
  logic                  hit;
  logic [SIZE_WIDTH-1:0] left_dec;
  logic [OFF_W-1:0]      off_inc;
  logic                  trunc;

  assign bad_len  = len_bad(data_byte);
  assign hit      = known_r[data_byte];
  assign left_dec = left_r - SIZE_WIDTH'(1);
  assign off_inc  = off_r + OFF_W'(1);

  // next state
  always_comb begin
    phase_step = phase_r;
    sticky_nxt = sticky_r;
    left_nxt   = left_r;
    off_nxt    = off_r;
    cur_nxt    = cur_r;
    step_nxt   = step_r;
    ecode_nxt  = ecode_r;
    ehigh_nxt  = ehigh_r;
    wr         = '0;
    unique case (phase_r)
      PH_TABLE_CODE: begin
        if ((data_byte == TABLE_CODE) && !stream_end) begin
          phase_step = PH_TABLE_LEN;
        end else begin
          sticky_nxt = ST_NO_TABLE;
          phase_step = PH_ERROR;
        end
      end
      PH_TABLE_LEN: begin
        if (bad_len && !(stream_end && (data_byte > 8'd1))) begin
          sticky_nxt = ST_BAD_LEN;
          phase_step = PH_ERROR;
        end else begin
          wr.en      = 1'b1;
          wr.addr    = TABLE_CODE;
          wr.data    = SIZE_WIDTH'(data_byte);
          left_nxt   = SIZE_WIDTH'(data_byte - 8'd1);
          off_nxt    = OFF_W'(1);
          step_nxt   = ENT_CODE;
          phase_step = (data_byte == 8'd1) ? PH_EVENT_CODE : PH_TABLE_BODY;
        end
      end
      PH_TABLE_BODY: begin
        off_nxt  = off_inc;
        left_nxt = left_dec;
        unique case (step_r)
          ENT_CODE: begin
            ecode_nxt = data_byte;
            step_nxt  = ENT_HIGH;
          end
          ENT_HIGH: begin
            ehigh_nxt = data_byte;
            step_nxt  = ENT_LOW;
          end
          default: begin
            wr.en    = 1'b1;
            wr.addr  = ecode_r;
            wr.data  = SIZE_WIDTH'({ehigh_r, data_byte});
            step_nxt = ENT_CODE;
          end
        endcase
        if (left_dec == '0) begin
          phase_step = PH_EVENT_CODE;
        end
      end
      PH_EVENT_CODE: begin
        if (!hit) begin
          sticky_nxt = ST_UNKNOWN;
          phase_step = PH_ERROR;
        end else begin
          cur_nxt  = data_byte;
          left_nxt = size_rd;
          off_nxt  = '0;
          if (size_rd == '0) begin
            phase_step = (data_byte == END_CODE) ? PH_DONE : PH_EVENT_CODE;
          end else begin
            phase_step = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        off_nxt  = off_inc;
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_step = (cur_r == END_CODE) ? PH_DONE : PH_EVENT_CODE;
        end
      end
      default: begin
      end
    endcase
  end

  assign trunc = (sticky_nxt == ST_OK) &&
                 ((phase_step == PH_TABLE_LEN) || (phase_step == PH_TABLE_BODY) ||
                  (phase_step == PH_PAYLOAD));
  assign phase_nxt = stream_end ? PH_TABLE_CODE : phase_step;

  // result fields
  always_comb begin
    res            = '0;
    res.byte_out   = data_byte;
    res.byte_kind  = KIND_IGNORED;
    unique case (phase_r)
      PH_TABLE_CODE: begin
        if ((data_byte == TABLE_CODE) && !stream_end) begin
          res.event_code = TABLE_CODE;
          res.byte_kind  = KIND_TABLE;
        end
      end
      PH_TABLE_LEN: begin
        if (!(bad_len && !(stream_end && (data_byte > 8'd1)))) begin
          res.event_code  = TABLE_CODE;
          res.byte_kind   = KIND_TABLE;
          res.byte_offset = OFF_W'(1);
          res.event_last  = (data_byte == 8'd1);
        end
      end
      PH_TABLE_BODY: begin
        res.event_code  = TABLE_CODE;
        res.byte_kind   = KIND_TABLE;
        res.byte_offset = off_inc;
        res.event_last  = (left_dec == '0);
      end
      PH_EVENT_CODE: begin
        if (hit) begin
          res.event_code = data_byte;
          res.byte_kind  = KIND_CODE;
          res.event_last = (size_rd == '0);
        end
      end
      PH_PAYLOAD: begin
        res.event_code  = cur_r;
        res.byte_kind   = KIND_PAYLOAD;
        res.byte_offset = off_inc;
        res.event_last  = (left_dec == '0);
      end
      default: begin
      end
    endcase
    res.status = (stream_end && trunc) ? ST_TRUNC : sticky_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TABLE_CODE;
      sticky_r <= ST_OK;
      left_r   <= '0;
      off_r    <= '0;
      cur_r    <= '0;
      step_r   <= ENT_CODE;
      ecode_r  <= '0;
      ehigh_r  <= '0;
      known_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      if (stream_end) begin
        // stream done: back to the reset state
        sticky_r <= ST_OK;
        left_r   <= '0;
        off_r    <= '0;
        cur_r    <= '0;
        step_r   <= ENT_CODE;
        ecode_r  <= '0;
        ehigh_r  <= '0;
        known_r  <= '0;
      end else begin
        sticky_r <= sticky_nxt;
        left_r   <= left_nxt;
        off_r    <= off_nxt;
        cur_r    <= cur_nxt;
        step_r   <= step_nxt;
        ecode_r  <= ecode_nxt;
        ehigh_r  <= ehigh_nxt;
        if (wr.en) begin
          known_r[wr.addr] <= 1'b1;
        end
      end
    end
  end

  a_sticky_err: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != ST_OK) |-> (phase_r == PH_ERROR))
    else $error("sticky status set outside the error phase");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stream_end) |=> ((phase_r == PH_TABLE_CODE) && (known_r == '0) &&
                             (sticky_r == ST_OK)))
    else $error("stream end did not return to the start state");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res.byte_kind == KIND_IGNORED)) |->
      ((res.event_code == '0) && (res.byte_offset == '0) && !res.event_last))
    else $error("ignored byte carries event tagging");

  a_table_learned: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !stream_end && (phase_r == PH_TABLE_LEN) && (phase_nxt != PH_ERROR)) |=>
      known_r[TABLE_CODE])
    else $error("table length not learned as table size");

endmodule

>>> test/tb_event_stream_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_stream_deframer_core
// Drives raw event streams into the deframer (size table first, then events)
// and checks every tagged byte against an in-bench model of the framing, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_event_stream_deframer_core;
  import eds_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  event_stream_deframer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // framing model state
  logic [SIZE_WIDTH-1:0] learned_size [256];
  bit                    learned [256];
  phase_t                ph;
  logic [15:0]           remaining;
  logic [15:0]           pay_off;
  logic [7:0]            cur_code;
  logic [7:0]            ent_code;
  logic [7:0]            ent_high;
  entry_step_t           ent_step;
  status_t               held_status;

  res_t due_tags[$];
  int   mismatches;
  int   framed_sent;
  bit   gaps_on;
  bit   stalls_on;

  function automatic void restart_framer();
    foreach (learned[i]) learned[i] = 1'b0;
    ph          = PH_TABLE_CODE;
    remaining   = '0;
    pay_off     = '0;
    cur_code    = '0;
    ent_code    = '0;
    ent_high    = '0;
    ent_step    = ENT_CODE;
    held_status = ST_OK;
  endfunction

  function automatic res_t frame_byte(input logic [7:0] b, input logic fin);
    res_t        r;
    int unsigned lv;
    r.byte_out    = b;
    r.event_code  = '0;
    r.byte_offset = '0;
    r.byte_kind   = KIND_IGNORED;
    r.event_last  = 1'b0;
    lv            = 32'(b);
    case (ph)
      PH_TABLE_CODE: begin
        if (b == TABLE_CODE && !fin) begin
          r.event_code = TABLE_CODE;
          r.byte_kind  = KIND_TABLE;
          ph           = PH_TABLE_LEN;
        end else begin
          held_status = ST_NO_TABLE;
          ph          = PH_ERROR;
        end
      end
      PH_TABLE_LEN: begin
        // a bad length on the final byte still frames when it could hold entries
        if ((lv == 0 || (lv - 1) % 3 != 0) && !(fin && lv > 1)) begin
          held_status = ST_BAD_LEN;
          ph          = PH_ERROR;
        end else begin
          r.event_code             = TABLE_CODE;
          r.byte_kind              = KIND_TABLE;
          r.byte_offset            = 16'd1;
          learned_size[TABLE_CODE] = SIZE_WIDTH'(b);
          learned[TABLE_CODE]      = 1'b1;
          remaining                = {8'd0, b} - 16'd1;
          pay_off                  = 16'd1;
          ent_step                 = ENT_CODE;
          if (remaining == 16'd0) begin
            r.event_last = 1'b1;
            ph           = PH_EVENT_CODE;
          end else begin
            ph = PH_TABLE_BODY;
          end
        end
      end
      PH_TABLE_BODY: begin
        pay_off       = pay_off + 16'd1;
        r.event_code  = TABLE_CODE;
        r.byte_kind   = KIND_TABLE;
        r.byte_offset = pay_off;
        case (ent_step)
          ENT_CODE: begin
            ent_code = b;
            ent_step = ENT_HIGH;
          end
          ENT_HIGH: begin
            ent_high = b;
            ent_step = ENT_LOW;
          end
          default: begin
            learned_size[ent_code] = SIZE_WIDTH'({ent_high, b});
            learned[ent_code]      = 1'b1;
            ent_step               = ENT_CODE;
          end
        endcase
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          r.event_last = 1'b1;
          ph           = PH_EVENT_CODE;
        end
      end
      PH_EVENT_CODE: begin
        if (!learned[b]) begin
          held_status = ST_UNKNOWN;
          ph          = PH_ERROR;
        end else begin
          r.event_code = b;
          r.byte_kind  = KIND_CODE;
          cur_code     = b;
          remaining    = 16'(learned_size[b]);
          pay_off      = 16'd0;
          if (remaining == 16'd0) begin
            r.event_last = 1'b1;
            ph           = (b == END_CODE) ? PH_DONE : PH_EVENT_CODE;
          end else begin
            ph = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pay_off       = pay_off + 16'd1;
        r.event_code  = cur_code;
        r.byte_kind   = KIND_PAYLOAD;
        r.byte_offset = pay_off;
        remaining     = remaining - 16'd1;
        if (remaining == 16'd0) begin
          r.event_last = 1'b1;
          ph           = (cur_code == END_CODE) ? PH_DONE : PH_EVENT_CODE;
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (held_status == ST_OK && (ph inside {PH_TABLE_LEN, PH_TABLE_BODY, PH_PAYLOAD}))
        held_status = ST_TRUNC;
      r.status = held_status;
      restart_framer();
    end else begin
      r.status = held_status;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_tagged_byte();
    res_t want;
    if (due_tags.size() == 0) begin
      report_mismatch("result with nothing due", out_tdata[31:0], 32'd0);
      return;
    end
    want = due_tags.pop_front();
    if (out_tdata[7:0] != want.byte_out)
      report_mismatch("byte_out", 32'(out_tdata[7:0]), 32'(want.byte_out));
    if (out_tdata[15:8] != want.event_code)
      report_mismatch("event_code", 32'(out_tdata[15:8]), 32'(want.event_code));
    if (out_tdata[31:16] != want.byte_offset)
      report_mismatch("byte_offset", 32'(out_tdata[31:16]), 32'(want.byte_offset));
    if (out_tdata[34:32] != want.status)
      report_mismatch("status", 32'(out_tdata[34:32]), 32'(want.status));
    if (out_tuser != want.byte_kind)
      report_mismatch("byte_kind", 32'(out_tuser), 32'(want.byte_kind));
    if (out_tlast != want.event_last)
      report_mismatch("event_last", 32'(out_tlast), 32'(want.event_last));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_tagged_byte();
  end

  // result side backpressure
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic fin);
    res_t want;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = frame_byte(b, fin);
    due_tags.push_back(want);
    if (want.byte_kind != KIND_IGNORED) framed_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream(input byte_q_t s);
    for (int i = 0; i < s.size(); i++)
      send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic compose_stream(output byte_q_t s);
    logic [15:0] gsize [256];
    bit          gknown [256];
    logic [7:0]  known_codes[$];
    logic [7:0]  c;
    logic [15:0] sz;
    int          n;
    int          len;
    int          pick;
    int          cut;
    bit          stop;
    s = {};
    foreach (gknown[i]) gknown[i] = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
      return;
    end
    if (pick < 16) begin
      s.push_back(TABLE_CODE);
      do len = $urandom_range(0, 255); while (len != 0 && (len - 1) % 3 == 0);
      s.push_back(8'(len));
      repeat ($urandom_range(0, 4)) s.push_back(8'($urandom));
      return;
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 84) : $urandom_range(0, 6);
    s.push_back(TABLE_CODE);
    s.push_back(8'(1 + 3 * n));
    gsize[TABLE_CODE]  = 16'(1 + 3 * n);
    gknown[TABLE_CODE] = 1'b1;
    known_codes.push_back(TABLE_CODE);
    // codes drawn mostly from a narrow range so entries get overwritten
    repeat (n) begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(8'h30 + $urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       sz = 16'($urandom);
        1, 2:    sz = 16'($urandom_range(7, 40));
        default: sz = 16'($urandom_range(0, 6));
      endcase
      s.push_back(c);
      s.push_back(sz[15:8]);
      s.push_back(sz[7:0]);
      gsize[c]  = sz;
      gknown[c] = 1'b1;
      known_codes.push_back(c);
    end
    stop = 1'b0;
    for (int e = $urandom_range(0, 12); e > 0 && !stop; e--) begin
      if ($urandom_range(0, 24) == 0) begin
        do c = 8'($urandom); while (gknown[c]);
        s.push_back(c);
        stop = 1'b1;
      end else begin
        c = known_codes[$urandom_range(0, known_codes.size() - 1)];
        s.push_back(c);
        if (gsize[c] > 16'd48) begin
          // long event: a few payload bytes, then the stream ends inside it
          repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
          stop = 1'b1;
        end else begin
          repeat (gsize[c]) s.push_back(8'($urandom));
          if (c == END_CODE) stop = 1'b1;
        end
      end
    end
    if (stop) repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, s.size());
      while (s.size() > cut) s.delete(s.size() - 1);
    end
  endtask

  task automatic test_missing_table();
    byte_q_t seq;
    seq = '{8'h00};
    send_stream(seq);
    seq = '{TABLE_CODE};
    send_stream(seq);
  endtask

  task automatic test_bad_length();
    byte_q_t seq;
    seq = '{TABLE_CODE, 8'h00, 8'h11};
    send_stream(seq);
    // ends on a bad length that could hold entries: framed and truncated
    seq = '{TABLE_CODE, 8'h05};
    send_stream(seq);
  endtask

  task automatic test_overwrite_and_unknown();
    byte_q_t seq;
    seq = '{TABLE_CODE, 8'h07, END_CODE, 8'h00, 8'h00, TABLE_CODE, 8'h00, 8'h01,
            TABLE_CODE, 8'hFF, 8'h42, 8'hAA};
    send_stream(seq);
  endtask

  task automatic test_game_end();
    byte_q_t seq;
    seq = '{TABLE_CODE, 8'h04, END_CODE, 8'h00, 8'h00, END_CODE, 8'hFF};
    send_stream(seq);
  endtask

  task automatic test_random_streams(input int quota);
    byte_q_t s;
    int      goal;
    goal = framed_sent + quota;
    while (framed_sent < goal) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      compose_stream(s);
      send_stream(s);
    end
  endtask

  task automatic test_back_to_back(input int quota);
    byte_q_t s;
    int      goal;
    goal      = framed_sent + quota;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (framed_sent < goal) begin
      compose_stream(s);
      send_stream(s);
    end
  endtask

  initial begin
    int waited;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    mismatches  = 0;
    framed_sent = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    restart_framer();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_missing_table();
    test_bad_length();
    test_overwrite_and_unknown();
    test_game_end();
    test_random_streams(1800);
    test_back_to_back(150);
    in_tvalid <= 1'b0;

    waited = 0;
    while (due_tags.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (due_tags.size() != 0)
      report_mismatch("results never arrived", due_tags.size(), 0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
